### rtl/transposition_table_probe_store_macros.svh
// assertion helpers, clocked on clk and quiet while rst_n is low
`ifndef TRANSPOSITION_TABLE_PROBE_STORE_MACROS_SVH
`define TRANSPOSITION_TABLE_PROBE_STORE_MACROS_SVH

// property holds in the same cycle
`define TTPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define TTPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ttps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ttps_pkg;

  localparam int unsigned ENTRIES_DEF = 65536;
  localparam int unsigned KEY_W       = 64;
  localparam int unsigned MOD_BITS    = 4;
  localparam int unsigned MOD_STEPS   = KEY_W / MOD_BITS;
  localparam int unsigned IN_TDATA_W  = 144;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [1:0] BOUND_EXACT = 2'd0;
  localparam logic [1:0] BOUND_UPPER = 2'd1;
  localparam logic [1:0] BOUND_LOWER = 2'd2;
  localparam logic [3:0] KIND_MAX    = 4'd6;

  typedef enum logic [1:0] {
    OP_PROBE = 2'd0,
    OP_STORE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_READ,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic [6:0]         pad;
    logic [2:0]         move_kind;
    logic [5:0]         to_square;
    logic [5:0]         from_square;
    logic [1:0]         bound_kind;
    logic signed [15:0] beta_bound;
    logic signed [15:0] alpha_bound;
    logic signed [15:0] score_in;
    logic [7:0]         search_depth;
    logic [KEY_W-1:0]   position_key;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         pad;
    logic               written;
    logic [2:0]         best_kind;
    logic [5:0]         best_to;
    logic [5:0]         best_from;
    logic signed [15:0] score_out;
    logic               cutoff;
    logic               key_found;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [7:0]         depth;
    logic signed [15:0] score;
    logic [1:0]         bound;
    logic [3:0]         mv_kind;
    logic [5:0]         mv_to;
    logic [5:0]         mv_from;
  } entry_t;

endpackage

`default_nettype wire

### rtl/transposition_table_probe_store.sv
`timescale 1ns / 1ps
`default_nettype none
`include "transposition_table_probe_store_macros.svh"

// Direct-mapped transposition table of ENTRIES slots held in one single-port-write,
// registered-read memory. in_tuser carries the opcode (probe, store, clear, no-op);
// every accepted transfer gives exactly one result transfer. With ENTRIES a power of
// two a probe or store reads memory when accepted, then compares and writes back;
// otherwise the slot index is the key modulo ENTRIES, reduced 4 key bits per cycle,
// then the slot is read in its own state. A clear op sweeps the memory one entry per
// cycle and then reports its result. After reset the same sweep runs before the first
// input transfer is accepted. A finished result waits in the output register while
// the next item is taken in.
module transposition_table_probe_store #(
  parameter int unsigned ENTRIES = ttps_pkg::ENTRIES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // position_key, search_depth, score_in, alpha_bound, beta_bound, bound_kind,
  // from_square, to_square, move_kind, zero pad
  input  wire logic [ttps_pkg::IN_TDATA_W-1:0]    in_tdata,
  // opcode
  input  wire logic [ttps_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // key_found, cutoff, score_out, best_from, best_to, best_kind, written, zero pad
  output logic [ttps_pkg::OUT_TDATA_W-1:0]        out_tdata
);
  import ttps_pkg::*;

  localparam int unsigned IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam bit          POW2      = ((1 << IDX_W) == ENTRIES);
  localparam int unsigned MOD_CNT_W = $clog2(MOD_STEPS);
  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(ENTRIES - 1);
  localparam logic [IDX_W:0]   ENTRIES_W  = (IDX_W + 1)'(ENTRIES);
  localparam logic [MOD_CNT_W-1:0] MOD_LAST = MOD_CNT_W'(MOD_STEPS - 1);

  entry_t mem [ENTRIES];

  state_t    state_r, state_nxt;
  logic [IDX_W-1:0] clr_ptr_r, clr_ptr_nxt;
  logic      report_r, report_nxt;
  logic      out_valid_r;
  out_item_t out_data_r;

  in_item_t  in_item;
  in_item_t  req_r;
  op_t       op_r;
  entry_t    rd_data_r;
  entry_t    new_ent;
  entry_t    wr_data;
  logic [IDX_W-1:0] rem_r, rem_nxt;
  logic [KEY_W-1:0] key_sh_r, key_sh_nxt;
  logic [MOD_CNT_W-1:0] mod_cnt_r, mod_cnt_nxt;
  logic [IDX_W:0] mod_acc;
  logic [IDX_W-1:0] idx, rd_addr, wr_addr;
  logic      rd_en, mem_we, emit, replace, in_tready_c;
  logic      depth_ok, hit;
  out_item_t res;

  assign in_item    = in_item_t'(in_tdata);
  assign in_tready  = in_tready_c;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);
  assign idx        = POW2 ? req_r.position_key[IDX_W-1:0] : rem_r;

  // key modulo ENTRIES, a few bits per cycle, most significant first
  always_comb begin
    mod_acc = {1'b0, rem_r};
    for (int i = 0; i < MOD_BITS; i++) begin
      mod_acc = {mod_acc[IDX_W-1:0], key_sh_r[KEY_W-1-i]};
      if (mod_acc >= ENTRIES_W) begin
        mod_acc = mod_acc - ENTRIES_W;
      end
    end
  end

  always_comb begin
    new_ent.key     = req_r.position_key;
    new_ent.depth   = req_r.search_depth;
    new_ent.score   = req_r.score_in;
    new_ent.bound   = req_r.bound_kind;
    new_ent.mv_kind = {1'b0, req_r.move_kind};
    new_ent.mv_to   = req_r.to_square;
    new_ent.mv_from = req_r.from_square;
  end

  assign replace  = (rd_data_r.key == '0) || (rd_data_r.key == req_r.position_key) ||
                    (req_r.search_depth >= rd_data_r.depth);
  assign depth_ok = rd_data_r.depth >= req_r.search_depth;

  always_comb begin
    hit = 1'b0;
    if (depth_ok) begin
      if (rd_data_r.bound == BOUND_EXACT) begin
        hit = 1'b1;
      end else if (rd_data_r.bound == BOUND_UPPER) begin
        hit = rd_data_r.score <= req_r.alpha_bound;
      end else if (rd_data_r.bound == BOUND_LOWER) begin
        hit = rd_data_r.score >= req_r.beta_bound;
      end
    end
  end

  always_comb begin
    res = '0;
    case (op_r)
      OP_PROBE: begin
        if (rd_data_r.key == req_r.position_key) begin
          res.key_found = 1'b1;
          res.best_from = rd_data_r.mv_from;
          res.best_to   = rd_data_r.mv_to;
          res.best_kind = (rd_data_r.mv_kind <= KIND_MAX) ? rd_data_r.mv_kind[2:0] : 3'd0;
          res.cutoff    = hit;
          res.score_out = hit ? rd_data_r.score : 16'sd0;
        end
      end
      OP_STORE: res.written = replace;
      OP_CLEAR: res.written = 1'b1;
      default:  res = '0;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    clr_ptr_nxt = clr_ptr_r;
    report_nxt  = report_r;
    mod_cnt_nxt = mod_cnt_r;
    rem_nxt     = rem_r;
    key_sh_nxt  = key_sh_r;
    in_tready_c = 1'b0;
    mem_we      = 1'b0;
    wr_addr     = idx;
    wr_data     = new_ent;
    rd_en       = 1'b0;
    rd_addr     = idx;
    emit        = 1'b0;
    case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        wr_addr     = clr_ptr_r;
        wr_data     = '0;
        clr_ptr_nxt = clr_ptr_r + 1'b1;
        if (clr_ptr_r == LAST_IDX) begin
          clr_ptr_nxt = '0;
          report_nxt  = 1'b0;
          state_nxt   = report_r ? S_EXEC : S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready_c = 1'b1;
        if (in_tvalid) begin
          case (op_t'(in_tuser))
            OP_PROBE, OP_STORE: begin
              if (POW2) begin
                rd_en     = 1'b1;
                rd_addr   = in_item.position_key[IDX_W-1:0];
                state_nxt = S_EXEC;
              end else begin
                rem_nxt     = '0;
                key_sh_nxt  = in_item.position_key;
                mod_cnt_nxt = '0;
                state_nxt   = S_MOD;
              end
            end
            OP_CLEAR: begin
              report_nxt = 1'b1;
              state_nxt  = S_CLEAR;
            end
            default: state_nxt = S_EXEC;
          endcase
        end
      end
      S_MOD: begin
        rem_nxt     = mod_acc[IDX_W-1:0];
        key_sh_nxt  = key_sh_r << MOD_BITS;
        mod_cnt_nxt = mod_cnt_r + 1'b1;
        if (mod_cnt_r == MOD_LAST) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        rd_en     = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (!out_valid_r || out_tready) begin
          emit      = 1'b1;
          mem_we    = (op_r == OP_STORE) && replace;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_ptr_r   <= '0;
      report_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_ptr_r <= clr_ptr_nxt;
      report_r  <= report_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready_c) begin
      req_r <= in_item;
      op_r  <= op_t'(in_tuser);
    end
    rem_r     <= rem_nxt;
    key_sh_r  <= key_sh_nxt;
    mod_cnt_r <= mod_cnt_nxt;
    if (emit) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  `TTPS_ASSERT(a_write_src, !mem_we || state_r == S_CLEAR || (state_r == S_EXEC && emit), "memory write outside sweep or result cycle")
  `TTPS_ASSERT(a_store_wr, !(emit && op_r == OP_STORE && res.written) || mem_we, "store reported written without a memory write")
  `TTPS_ASSERT_NEXT(a_emit_valid, emit, out_valid_r, "result lost after emit")
  `TTPS_ASSERT(a_cut_found, !out_valid_r || !out_data_r.cutoff || out_data_r.key_found, "cutoff without key match")
  `TTPS_ASSERT(a_no_accept_busy, !(in_tready_c && (state_r == S_CLEAR || out_valid_r && state_r == S_EXEC)), "input taken while busy")

endmodule

`default_nettype wire

### sim/transposition_table_probe_store_tb.sv
`timescale 1ns / 1ps

module transposition_table_probe_store_tb;
  import ttps_pkg::*;

  localparam int STALL_LIMIT = 300000;
  localparam int RANDOM_ITEMS = 850;

  typedef struct {
    op_t       op;
    in_item_t  item;
    bit        pinned;
    out_item_t want;
  } stim_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [IN_TUSER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  entry_t slot_mem [bit [63:0]];
  out_item_t pending_results [$];
  stim_t directed_rows [$];
  logic [15:0] slot_pool [16];
  logic [47:0] hi_pool [16][3];

  int n_err = 0;
  int n_results = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit no_gaps = 1'b0;
  out_item_t mon_got, mon_want;

  transposition_table_probe_store u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  // table behavior: returns the result of one transfer and updates the shadow table
  function automatic out_item_t tt_apply(op_t op, in_item_t it);
    out_item_t r;
    entry_t e;
    bit [63:0] idx;
    bit hit;
    r = '0;
    hit = 1'b0;
    idx = it.position_key % 64'(ENTRIES_DEF);
    e = slot_mem.exists(idx) ? slot_mem[idx] : '0;
    case (op)
      OP_PROBE: begin
        if (e.key == it.position_key) begin
          r.key_found = 1'b1;
          r.best_from = e.mv_from;
          r.best_to = e.mv_to;
          r.best_kind = (e.mv_kind <= KIND_MAX) ? e.mv_kind[2:0] : 3'd0;
          if (e.depth >= it.search_depth) begin
            hit = (e.bound == BOUND_EXACT) ||
                  (e.bound == BOUND_UPPER && $signed(e.score) <= $signed(it.alpha_bound)) ||
                  (e.bound == BOUND_LOWER && $signed(e.score) >= $signed(it.beta_bound));
          end
          if (hit) begin
            r.cutoff = 1'b1;
            r.score_out = e.score;
          end
        end
      end
      OP_STORE: begin
        if (e.key == '0 || e.key == it.position_key || it.search_depth >= e.depth) begin
          e.key = it.position_key;
          e.depth = it.search_depth;
          e.score = it.score_in;
          e.bound = it.bound_kind;
          e.mv_kind = {1'b0, it.move_kind};
          e.mv_to = it.to_square;
          e.mv_from = it.from_square;
          slot_mem[idx] = e;
          r.written = 1'b1;
        end
      end
      OP_CLEAR: begin
        slot_mem.delete();
        r.written = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic stim_t row(op_t op, logic [63:0] key, logic [7:0] dep, int sc, int al,
                                int be, logic [1:0] bnd, logic [5:0] fr, logic [5:0] tsq,
                                logic [2:0] mk);
    stim_t s;
    s.op = op;
    s.item = '0;
    s.item.position_key = key;
    s.item.search_depth = dep;
    s.item.score_in = 16'(sc);
    s.item.alpha_bound = 16'(al);
    s.item.beta_bound = 16'(be);
    s.item.bound_kind = bnd;
    s.item.from_square = fr;
    s.item.to_square = tsq;
    s.item.move_kind = mk;
    s.pinned = 1'b0;
    s.want = '0;
    return s;
  endfunction

  function automatic stim_t pin(stim_t s, bit kf, bit co, int sc, logic [5:0] fr,
                                logic [5:0] tsq, logic [2:0] kd, bit wr);
    s.pinned = 1'b1;
    s.want = '0;
    s.want.key_found = kf;
    s.want.cutoff = co;
    s.want.score_out = 16'(sc);
    s.want.best_from = fr;
    s.want.best_to = tsq;
    s.want.best_kind = kd;
    s.want.written = wr;
    return s;
  endfunction

  function automatic logic [15:0] score_pick();
    if ($urandom_range(0, 1)) return 16'($urandom_range(0, 40) - 20);
    return 16'($urandom);
  endfunction

  function automatic stim_t rand_stim();
    stim_t s;
    int r;
    int p;
    s = row(OP_NOP, '0, '0, 0, 0, 0, '0, '0, '0, '0);
    r = $urandom_range(0, 99);
    if (r < 42) s.op = OP_PROBE;
    else if (r < 88) s.op = OP_STORE;
    else s.op = OP_NOP;
    r = $urandom_range(0, 99);
    p = $urandom_range(0, 15);
    if (r < 3) s.item.position_key = '0;
    else if (r < 13) s.item.position_key = {$urandom, $urandom};
    else s.item.position_key = {hi_pool[p][$urandom_range(0, 2)], slot_pool[p]};
    s.item.search_depth = $urandom_range(0, 1) ? 8'($urandom_range(0, 6)) : 8'($urandom);
    s.item.score_in = score_pick();
    s.item.alpha_bound = score_pick();
    s.item.beta_bound = score_pick();
    s.item.bound_kind = 2'($urandom_range(0, 3));
    s.item.from_square = 6'($urandom);
    s.item.to_square = 6'($urandom);
    s.item.move_kind = 3'($urandom);
    return s;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send(stim_t s);
    out_item_t w;
    while (!no_gaps && $urandom_range(0, 99) < 12) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= s.item;
    in_tuser <= s.op;
    do @(posedge clk); while (!in_tready);
    w = tt_apply(s.op, s.item);
    pending_results.push_back(s.pinned ? s.want : w);
    @(negedge clk);
  endtask

  task automatic note_err(string msg);
    if (n_err < 10) $display("mismatch at result %0d: %s", n_results, msg);
    n_err++;
  endtask

  task automatic check_field(string fld, logic [15:0] want, logic [15:0] got);
    if (want !== got) note_err($sformatf("%s expected %0h got %0h", fld, want, got));
  endtask

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 80;
    end
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (no_gaps) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= 12);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      mon_got = out_item_t'(out_tdata);
      if (pending_results.size() == 0) begin
        note_err($sformatf("unexpected transfer %h", out_tdata));
      end else begin
        mon_want = pending_results.pop_front();
        check_field("key_found", 16'(mon_want.key_found), 16'(mon_got.key_found));
        check_field("cutoff", 16'(mon_want.cutoff), 16'(mon_got.cutoff));
        check_field("score_out", mon_want.score_out, mon_got.score_out);
        check_field("best_from", 16'(mon_want.best_from), 16'(mon_got.best_from));
        check_field("best_to", 16'(mon_want.best_to), 16'(mon_got.best_to));
        check_field("best_kind", 16'(mon_want.best_kind), 16'(mon_got.best_kind));
        check_field("written", 16'(mon_want.written), 16'(mon_got.written));
      end
      n_results++;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("transposition_table_probe_store regression: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    foreach (slot_pool[p]) begin
      slot_pool[p] = 16'($urandom);
      for (int k = 0; k < 3; k++) hi_pool[p][k] = {16'($urandom), $urandom};
    end
    slot_pool[0] = 16'h0000;
    slot_pool[1] = 16'hFFFF;
    hi_pool[0][0] = '0;

    // empty table, extremes, every bound kind, move kinds 1 to 4, 6 and 7
    directed_rows.push_back(pin(row(OP_PROBE, 64'h0, 0, 0, 0, 0, 0, 0, 0, 0),
                                1, 1, 0, 0, 0, 0, 0));
    directed_rows.push_back(pin(row(OP_PROBE, 64'h0, 255, 0, 0, 0, 0, 0, 0, 0),
                                1, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(pin(row(OP_PROBE, '1, 0, 0, 0, 0, 0, 0, 0, 0),
                                0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(pin(row(OP_NOP, '1, 255, -1, -1, -1, 3, 63, 63, 7),
                                0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(pin(row(OP_STORE, '1, 255, 32767, -32768, 32767, BOUND_EXACT,
                                    63, 63, 6), 0, 0, 0, 0, 0, 0, 1));
    directed_rows.push_back(pin(row(OP_PROBE, '1, 255, 0, 0, 0, 0, 0, 0, 0),
                                1, 1, 32767, 63, 63, 6, 0));
    directed_rows.push_back(pin(row(OP_STORE, 64'h1_FFFF, 254, 1, 0, 0, BOUND_EXACT, 1, 1, 1),
                                0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(OP_STORE, 64'h1_FFFF, 255, -5, 0, 0, BOUND_LOWER, 1, 2, 3));
    directed_rows.push_back(row(OP_PROBE, 64'h1_FFFF, 255, 0, 0, -5, 0, 0, 0, 0));
    directed_rows.push_back(row(OP_PROBE, 64'h1_FFFF, 255, 0, 0, -4, 0, 0, 0, 0));
    directed_rows.push_back(row(OP_PROBE, '1, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(OP_STORE, 64'h8000_0000_0000_0000, 0, -32768, 0, 0,
                                BOUND_UPPER, 0, 0, 7));
    directed_rows.push_back(row(OP_PROBE, 64'h8000_0000_0000_0000, 0, 0, -32768, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(OP_PROBE, 64'h8000_0000_0000_0000, 1, 0, -32768, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(OP_STORE, 64'h0000_1234_0000_0002, 9, 11, 0, 0, 3, 5, 6, 2));
    directed_rows.push_back(row(OP_PROBE, 64'h0000_1234_0000_0002, 0, 0, 32767, -32768,
                                0, 0, 0, 0));
    directed_rows.push_back(row(OP_STORE, 64'h5555_AAAA_0000_0003, 3, 50, 0, 0, BOUND_UPPER,
                                9, 10, 1));
    directed_rows.push_back(row(OP_PROBE, 64'h5555_AAAA_0000_0003, 3, 0, 49, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(OP_PROBE, 64'h5555_AAAA_0000_0003, 3, 0, 50, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(OP_PROBE, 64'h0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(pin(row(OP_CLEAR, '1, 255, -1, -1, -1, 3, 63, 63, 7),
                                0, 0, 0, 0, 0, 0, 1));
    directed_rows.push_back(pin(row(OP_PROBE, '1, 0, 0, 0, 0, 0, 0, 0, 0),
                                0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(pin(row(OP_PROBE, 64'h0, 0, 0, 0, 0, 0, 0, 0, 0),
                                1, 1, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(OP_STORE, 64'h0, 0, 7, 0, 0, BOUND_LOWER, 4, 4, 4));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) send(directed_rows[i]);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 150) hold_req = 1'b1;
      if (i == 450) begin
        in_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      no_gaps = (i >= 500 && i < 650);
      if (i == 300 || i == 600) send(row(OP_CLEAR, {$urandom, $urandom}, 0, 0, 0, 0, 0, 0, 0, 0));
      else send(rand_stim());
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_err == 0) begin
      $display("transposition_table_probe_store regression: pass");
    end else begin
      $display("transposition_table_probe_store regression: fail");
    end
    $finish;
  end

endmodule
